// ===== design/matrix_multiply_core_macros.svh =====
// ----------------------------------------------------------------------------
// Matrix multiply core assertion macros
// Concurrent assertion wrappers that compile away under synthesis.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define MMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== design/mmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Matrix multiply core package
// Shared widths, codes, types and helpers of the matrix multiply core.
// ----------------------------------------------------------------------------
package mmc_pkg;

    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int FUNC_W    = 2;
    localparam int IDX_W     = 3;
    localparam int ELEM_W    = 16;
    localparam int PROD_W    = 32;
    localparam int ACC_W     = 35;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 48;

    typedef logic [FUNC_W-1:0]    t_func;
    typedef logic [CFG_IDX_W-1:0] t_reg_idx;

    localparam t_func FUNC_WRITE_A = 2'd0;
    localparam t_func FUNC_WRITE_B = 2'd1;
    localparam t_func FUNC_MULTIPLY = 2'd2;

    localparam t_reg_idx REG_A_ROWS = 2'd0;
    localparam t_reg_idx REG_A_COLS = 2'd1;
    localparam t_reg_idx REG_B_ROWS = 2'd2;
    localparam t_reg_idx REG_B_COLS = 2'd3;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_op;

    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [ACC_W-1:0] value;
        logic                    last;
        logic                    err;
    } t_result;

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] lim);
        logic [CFG_W-1:0] r;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > lim) begin
            r = lim;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== design/mmc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module mmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/mmc_mac.sv =====
// ----------------------------------------------------------------------------
// Matrix multiply core MAC unit
// Shared multiplier with a registered product and a 35-bit accumulator.
// ----------------------------------------------------------------------------
`include "matrix_multiply_core_macros.svh"

module mmc_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mmc_pkg::t_mac_op                    i_op,
    input  logic signed [mmc_pkg::ELEM_W-1:0]   i_a,
    input  logic signed [mmc_pkg::ELEM_W-1:0]   i_b,
    output logic                                o_done,
    output logic signed [mmc_pkg::ACC_W-1:0]    o_acc
);
    import mmc_pkg::*;

    t_mac_op                  r_p_op;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic                     r_done;
    logic signed [ACC_W-1:0]  prod_ext;

    assign prod_ext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_op <= '0;
            r_done <= 1'b0;
        end else begin
            r_p_op <= i_op;
            r_done <= r_p_op.valid && r_p_op.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        if (r_p_op.valid) begin
            r_acc <= r_p_op.first ? prod_ext : r_acc + prod_ext;
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

    `MMC_ASSERT_NEXT(a_done_after_last, i_clk, i_rst_n, r_p_op.valid && r_p_op.last, r_done, "final product did not complete the sum")
    `MMC_ASSERT_IMP(a_done_has_source, i_clk, i_rst_n, r_done, $past(r_p_op.valid), "sum completed without a product")
    `MMC_ASSERT_NEXT(a_product_follows_op, i_clk, i_rst_n, i_op.valid, r_p_op.valid, "operand pair was lost")

endmodule

// ===== design/matrix_multiply_core.sv =====
// ----------------------------------------------------------------------------
// Matrix multiply core: element writes are taken whenever the core is idle.
// A multiply gives a_rows * b_cols results, each a sum of a_cols products on the shared MAC.
// A shape error gives a single result, marked last. No request is taken until the final
// result is registered. Reset is synchronous and clears the store valid bits.
// ----------------------------------------------------------------------------
`include "matrix_multiply_core_macros.svh"

module matrix_multiply_core #(
    parameter int MAX_DIM = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mmc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mmc_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // row_index[2:0], col_index[5:3], elem_value[21:6], zeros[23:22]
    input  logic [mmc_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // func[1:0]
    input  logic [mmc_pkg::FUNC_W-1:0]       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_row[2:0], out_col[5:3], out_value[40:6], zeros[47:41]
    output logic [mmc_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic                             m_axis_tlast,
    // shape_error[0]
    output logic                             m_axis_tuser
);
    import mmc_pkg::*;

    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW    = 2 * IW;
    localparam int DEPTH = 1 << AW;
    localparam logic [CFG_W-1:0] DIM_LIM = CFG_W'(MAX_DIM);
    localparam logic [CFG_W-1:0] ONE     = CFG_W'(1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [CFG_W-1:0] r_a_rows, r_a_cols, r_b_rows, r_b_cols;
    logic [IW-1:0]    r_i, n_i, r_j, n_j, r_k, n_k;
    logic             r_issue, n_issue;
    t_result          r_res, n_res, r_out, n_out;
    logic             r_m_valid, n_m_valid;
    logic [DEPTH-1:0] r_a_vld, r_b_vld;
    logic             r_a_rv, r_b_rv;
    t_mac_op          r_rd_op;

    logic                     s_accept;
    t_func                    in_func;
    logic [IDX_W-1:0]         in_row, in_col;
    logic [ELEM_W-1:0]        in_val;
    logic                     wr_ok, we_a, we_b;
    logic [AW-1:0]            waddr, raddr_a, raddr_b;
    logic [ELEM_W-1:0]        rdata_a, rdata_b;
    logic signed [ELEM_W-1:0] op_a, op_b;
    logic                     i_last, j_last, k_last;
    logic                     mac_done;
    logic signed [ACC_W-1:0]  mac_acc;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign in_func = s_axis_tuser;
    assign in_row  = s_axis_tdata[2:0];
    assign in_col  = s_axis_tdata[5:3];
    assign in_val  = s_axis_tdata[21:6];

    assign wr_ok = ({1'b0, in_row} < DIM_LIM) && ({1'b0, in_col} < DIM_LIM);
    assign we_a  = s_accept && (in_func == FUNC_WRITE_A) && wr_ok;
    assign we_b  = s_accept && (in_func == FUNC_WRITE_B) && wr_ok;
    assign waddr = {in_row[IW-1:0], in_col[IW-1:0]};

    assign raddr_a = {r_i, r_k};
    assign raddr_b = {r_k, r_j};

    assign i_last = (CFG_W'(r_i) == r_a_rows - ONE);
    assign j_last = (CFG_W'(r_j) == r_b_cols - ONE);
    assign k_last = (CFG_W'(r_k) == r_a_cols - ONE);

    mmc_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (in_val),
        .i_raddr (raddr_a),
        .o_rdata (rdata_a)
    );

    mmc_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (in_val),
        .i_raddr (raddr_b),
        .o_rdata (rdata_b)
    );

    assign op_a = r_a_rv ? rdata_a : '0;
    assign op_b = r_b_rv ? rdata_b : '0;

    mmc_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (r_rd_op),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_done  (mac_done),
        .o_acc   (mac_acc)
    );

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_issue   = r_issue;
        n_res     = r_res;
        n_out     = r_out;
        n_m_valid = r_m_valid && !m_axis_tready;
        case (r_state)
            S_IDLE: begin
                if (s_accept && (in_func == FUNC_MULTIPLY)) begin
                    if (r_a_cols != r_b_rows) begin
                        n_res.row   = '0;
                        n_res.col   = '0;
                        n_res.value = '0;
                        n_res.last  = 1'b1;
                        n_res.err   = 1'b1;
                        n_state     = S_DONE;
                    end else begin
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                        n_issue = 1'b1;
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (r_issue) begin
                    if (k_last) begin
                        n_issue = 1'b0;
                    end else begin
                        n_k = r_k + IW'(1);
                    end
                end
                if (mac_done) begin
                    n_res.row   = IDX_W'(r_i);
                    n_res.col   = IDX_W'(r_j);
                    n_res.value = mac_acc;
                    n_res.last  = i_last && j_last;
                    n_res.err   = 1'b0;
                    n_state     = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_m_valid = 1'b1;
                    n_out     = r_res;
                    if (r_res.last) begin
                        n_state = S_IDLE;
                    end else begin
                        if (i_last) begin
                            n_i = '0;
                            n_j = r_j + IW'(1);
                        end else begin
                            n_i = r_i + IW'(1);
                        end
                        n_k     = '0;
                        n_issue = 1'b1;
                        n_state = S_RUN;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_issue   <= 1'b0;
            r_m_valid <= 1'b0;
            r_rd_op   <= '0;
            r_a_vld   <= '0;
            r_b_vld   <= '0;
            r_a_rows  <= ONE;
            r_a_cols  <= ONE;
            r_b_rows  <= ONE;
            r_b_cols  <= ONE;
        end else begin
            r_state   <= n_state;
            r_issue   <= n_issue;
            r_m_valid <= n_m_valid;
            r_rd_op.valid <= r_issue;
            r_rd_op.first <= (r_k == '0);
            r_rd_op.last  <= k_last;
            if (we_a) begin
                r_a_vld[waddr] <= 1'b1;
            end
            if (we_b) begin
                r_b_vld[waddr] <= 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_A_ROWS: r_a_rows <= clamp_dim(i_cfg_data, DIM_LIM);
                    REG_A_COLS: r_a_cols <= clamp_dim(i_cfg_data, DIM_LIM);
                    REG_B_ROWS: r_b_rows <= clamp_dim(i_cfg_data, DIM_LIM);
                    REG_B_COLS: r_b_cols <= clamp_dim(i_cfg_data, DIM_LIM);
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_j    <= n_j;
        r_k    <= n_k;
        r_res  <= n_res;
        r_out  <= n_out;
        r_a_rv <= r_a_vld[raddr_a];
        r_b_rv <= r_b_vld[raddr_b];
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {7'b0, r_out.value, r_out.col, r_out.row};
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tuser  = r_out.err;

    `MMC_ASSERT_IMP(a_err_is_last, i_clk, i_rst_n, (r_state == S_DONE) && r_res.err, r_res.last, "shape error result not marked last")
    `MMC_ASSERT_IMP(a_done_in_run, i_clk, i_rst_n, mac_done, r_state == S_RUN, "sum completed outside a product run")
    `MMC_ASSERT_IMP(a_issue_in_run, i_clk, i_rst_n, r_issue, r_state == S_RUN, "store read issued outside a product run")
    `MMC_ASSERT_NEXT(a_busy_after_multiply, i_clk, i_rst_n, s_accept && (in_func == FUNC_MULTIPLY), !s_axis_tready, "request taken while a multiply is pending")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiply core testbench
// Loads elements of A and B, writes the dimension registers between request
// bursts and checks every product element, in column-major order, against a
// predictor kept in step with the stores. A directed table comes first, then
// random phases with idle bursts on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb;
    import mmc_pkg::*;

    localparam t_func FUNC_UNUSED   = 2'd3;
    localparam int    ITEM_TARGET   = 150;
    localparam int    STEADY_FROM   = 120;
    localparam int    SETTLE_CYCLES = 16;
    localparam int    LONG_HOLD     = 300;
    localparam int    CYCLE_LIMIT   = 1000000;

    typedef enum logic {STEP_ITEM, STEP_CFG} t_step_kind;

    typedef struct packed {
        t_step_kind              kind;
        t_func                   func;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [ELEM_W-1:0] val;
        t_reg_idx                reg_idx;
        logic [CFG_W-1:0]        reg_val;
        logic                    typed;
        logic signed [ACC_W-1:0] exp_value;
        logic                    exp_err;
    } t_dir_step;

    localparam t_dir_step DIRECTED [23] = '{
        '{STEP_ITEM, FUNC_MULTIPLY, 3'd0, 3'd0, 16'sd0, REG_A_ROWS, 4'd0, 1'b1, 35'sd0, 1'b0},
        '{STEP_ITEM, FUNC_WRITE_A, 3'd0, 3'd0, -16'sd32768, REG_A_ROWS, 4'd0, 1'b0, 35'sd0, 1'b0},
        '{STEP_ITEM, FUNC_WRITE_B, 3'd0, 3'd0, -16'sd32768, REG_A_ROWS, 4'd0, 1'b0, 35'sd0, 1'b0},
        '{STEP_ITEM, FUNC_MULTIPLY, 3'd0, 3'd0, 16'sd0, REG_A_ROWS, 4'd0, 1'b1,
          35'sd1073741824, 1'b0},
        '{STEP_ITEM, FUNC_WRITE_A, 3'd0, 3'd0, 16'sd32767, REG_A_ROWS, 4'd0, 1'b0, 35'sd0, 1'b0},
        '{STEP_ITEM, FUNC_MULTIPLY, 3'd0, 3'd0, 16'sd0, REG_A_ROWS, 4'd0, 1'b1,
          -35'sd1073709056, 1'b0},
        '{STEP_ITEM, FUNC_UNUSED, 3'd7, 3'd7, -16'sd1, REG_A_ROWS, 4'd0, 1'b0, 35'sd0, 1'b0},
        '{STEP_ITEM, FUNC_MULTIPLY, 3'd7, 3'd7, -16'sd1, REG_A_ROWS, 4'd0, 1'b1,
          -35'sd1073709056, 1'b0},
        '{STEP_ITEM, FUNC_WRITE_A, 3'd7, 3'd7, 16'sd32767, REG_A_ROWS, 4'd0, 1'b0, 35'sd0, 1'b0},
        '{STEP_ITEM, FUNC_WRITE_B, 3'd7, 3'd7, -16'sd1, REG_A_ROWS, 4'd0, 1'b0, 35'sd0, 1'b0},
        '{STEP_CFG, FUNC_WRITE_A, 3'd0, 3'd0, 16'sd0, REG_A_COLS, 4'd0, 1'b0, 35'sd0, 1'b0},
        '{STEP_CFG, FUNC_WRITE_A, 3'd0, 3'd0, 16'sd0, REG_B_ROWS, 4'd2, 1'b0, 35'sd0, 1'b0},
        '{STEP_ITEM, FUNC_MULTIPLY, 3'd5, 3'd2, 16'sd99, REG_A_ROWS, 4'd0, 1'b1, 35'sd0, 1'b1},
        '{STEP_CFG, FUNC_WRITE_A, 3'd0, 3'd0, 16'sd0, REG_A_ROWS, 4'd15, 1'b0, 35'sd0, 1'b0},
        '{STEP_CFG, FUNC_WRITE_A, 3'd0, 3'd0, 16'sd0, REG_A_COLS, 4'd15, 1'b0, 35'sd0, 1'b0},
        '{STEP_CFG, FUNC_WRITE_A, 3'd0, 3'd0, 16'sd0, REG_B_ROWS, 4'd9, 1'b0, 35'sd0, 1'b0},
        '{STEP_CFG, FUNC_WRITE_A, 3'd0, 3'd0, 16'sd0, REG_B_COLS, 4'd8, 1'b0, 35'sd0, 1'b0},
        '{STEP_ITEM, FUNC_MULTIPLY, 3'd0, 3'd0, 16'sd0, REG_A_ROWS, 4'd0, 1'b0, 35'sd0, 1'b0},
        '{STEP_CFG, FUNC_WRITE_A, 3'd0, 3'd0, 16'sd0, REG_A_ROWS, 4'd0, 1'b0, 35'sd0, 1'b0},
        '{STEP_CFG, FUNC_WRITE_A, 3'd0, 3'd0, 16'sd0, REG_B_COLS, 4'd0, 1'b0, 35'sd0, 1'b0},
        '{STEP_ITEM, FUNC_WRITE_B, 3'd7, 3'd0, -16'sd32768, REG_A_ROWS, 4'd0, 1'b0, 35'sd0, 1'b0},
        '{STEP_ITEM, FUNC_WRITE_A, 3'd0, 3'd7, -16'sd32768, REG_A_ROWS, 4'd0, 1'b0, 35'sd0, 1'b0},
        '{STEP_ITEM, FUNC_MULTIPLY, 3'd0, 3'd0, 16'sd0, REG_A_ROWS, 4'd0, 1'b0, 35'sd0, 1'b0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    t_reg_idx             i_cfg_index = REG_A_ROWS;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    t_func                s_axis_tuser = FUNC_WRITE_A;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 m_axis_tuser;

    logic signed [ELEM_W-1:0] mat_a [64];
    logic signed [ELEM_W-1:0] mat_b [64];
    int unsigned dim_a_rows = 1, dim_a_cols = 1, dim_b_rows = 1, dim_b_cols = 1;

    t_result expected_products [$];
    int      mismatches = 0;
    int      items_sent = 0;
    int      cycles = 0;
    bit      steady = 1'b0;
    bit      want_hold = 1'b0;
    bit      hold_done = 1'b0;
    int      hold_left = 0;
    int      stall_left = 0;

    matrix_multiply_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic int unsigned fit_dim(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return 1;
        end
        if (v > 4'd8) begin
            return 8;
        end
        return 32'(v);
    endfunction

    function automatic void compute_products(input t_func f, input logic [IDX_W-1:0] r,
                                             input logic [IDX_W-1:0] c,
                                             input logic signed [ELEM_W-1:0] v,
                                             output t_result res [$]);
        longint  acc;
        t_result one;
        res = {};
        case (f)
            FUNC_WRITE_A: begin
                mat_a[{r, c}] = v;
            end
            FUNC_WRITE_B: begin
                mat_b[{r, c}] = v;
            end
            FUNC_MULTIPLY: begin
                if (dim_a_cols != dim_b_rows) begin
                    one = '0;
                    one.last = 1'b1;
                    one.err = 1'b1;
                    res.push_back(one);
                end else begin
                    for (int j = 0; j < dim_b_cols; j++) begin
                        for (int i = 0; i < dim_a_rows; i++) begin
                            acc = 0;
                            for (int k = 0; k < dim_a_cols; k++) begin
                                acc += longint'(mat_a[i * 8 + k]) * longint'(mat_b[k * 8 + j]);
                            end
                            one.row = IDX_W'(i);
                            one.col = IDX_W'(j);
                            one.value = acc[ACC_W-1:0];
                            one.last = (i + 1 == dim_a_rows) && (j + 1 == dim_b_cols);
                            one.err = 1'b0;
                            res.push_back(one);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_product(input t_result got);
        t_result want;
        if (expected_products.size() == 0) begin
            $display("%0t: unexpected result row %0d col %0d value %0d last %0b err %0b",
                     $realtime, got.row, got.col, got.value, got.last, got.err);
            mismatches++;
            return;
        end
        want = expected_products.pop_front();
        if (got.row !== want.row) begin
            $display("%0t: row expected %0d actual %0d", $realtime, want.row, got.row);
            mismatches++;
        end
        if (got.col !== want.col) begin
            $display("%0t: column expected %0d actual %0d", $realtime, want.col, got.col);
            mismatches++;
        end
        if (got.value !== want.value) begin
            $display("%0t: value expected %0d actual %0d", $realtime, want.value, got.value);
            mismatches++;
        end
        if (got.last !== want.last) begin
            $display("%0t: last expected %0b actual %0b", $realtime, want.last, got.last);
            mismatches++;
        end
        if (got.err !== want.err) begin
            $display("%0t: shape error expected %0b actual %0b", $realtime, want.err, got.err);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.row = m_axis_tdata[2:0];
                got.col = m_axis_tdata[5:3];
                got.value = m_axis_tdata[40:6];
                got.last = m_axis_tlast;
                got.err = m_axis_tuser;
                check_product(got);
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (want_hold && !hold_done) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!steady && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 14) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input t_func f, input logic [IDX_W-1:0] r,
                             input logic [IDX_W-1:0] c, input logic signed [ELEM_W-1:0] v,
                             input bit typed, input t_result typed_res);
        t_result fresh [$];
        if (!steady && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, v, c, r};
        s_axis_tuser <= f;
        do @(posedge i_clk); while (!s_axis_tready);
        compute_products(f, r, c, v, fresh);
        if (typed) begin
            expected_products.push_back(typed_res);
        end else begin
            expected_products = {expected_products, fresh};
        end
        if (f != FUNC_UNUSED) begin
            items_sent++;
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_products.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_A_ROWS: dim_a_rows = fit_dim(val);
            REG_A_COLS: dim_a_cols = fit_dim(val);
            REG_B_ROWS: dim_b_rows = fit_dim(val);
            REG_B_COLS: dim_b_cols = fit_dim(val);
            default: begin
            end
        endcase
    endtask

    function automatic logic [CFG_W-1:0] pick_dim();
        case ($urandom_range(0, 7))
            0: return 4'd0;
            1: return CFG_W'($urandom_range(9, 15));
            2: return 4'd8;
            3: return 4'd1;
            default: return CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic signed [ELEM_W-1:0] pick_elem();
        case ($urandom_range(0, 5))
            0: return -16'sd32768;
            1: return 16'sd32767;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    initial begin
        t_result          typed_res;
        bit               quiet;
        int               phase;
        int               sel;
        logic [CFG_W-1:0] inner;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        t_func            f;

        foreach (mat_a[n]) begin
            mat_a[n] = '0;
            mat_b[n] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        quiet = 1'b1;
        foreach (DIRECTED[n]) begin
            if (DIRECTED[n].kind == STEP_CFG) begin
                if (!quiet) begin
                    settle();
                    quiet = 1'b1;
                end
                write_reg(DIRECTED[n].reg_idx, DIRECTED[n].reg_val);
            end else begin
                quiet = 1'b0;
                typed_res = '0;
                typed_res.value = DIRECTED[n].exp_value;
                typed_res.last = 1'b1;
                typed_res.err = DIRECTED[n].exp_err;
                send_item(DIRECTED[n].func, DIRECTED[n].row, DIRECTED[n].col,
                          DIRECTED[n].val, DIRECTED[n].typed, typed_res);
            end
        end

        items_sent = 0;
        phase = 0;
        typed_res = '0;
        while (items_sent < ITEM_TARGET) begin
            settle();
            if (items_sent >= STEADY_FROM) begin
                steady = 1'b1;
            end
            if (phase == 1) begin
                write_reg(REG_A_ROWS, 4'd8);
                write_reg(REG_A_COLS, 4'd8);
                write_reg(REG_B_ROWS, 4'd8);
                write_reg(REG_B_COLS, 4'd8);
                want_hold = 1'b1;
            end else begin
                inner = pick_dim();
                write_reg(REG_A_ROWS, pick_dim());
                write_reg(REG_A_COLS, inner);
                write_reg(REG_B_ROWS, ($urandom_range(0, 3) == 0) ? pick_dim() : inner);
                write_reg(REG_B_COLS, pick_dim());
            end
            repeat ($urandom_range(4, 16)) begin
                sel = $urandom_range(0, 9);
                if (sel == 0) begin
                    send_item(FUNC_UNUSED, IDX_W'($urandom), IDX_W'($urandom), pick_elem(),
                              1'b0, typed_res);
                end else if (sel < 8) begin
                    if ($urandom_range(0, 1) == 0) begin
                        f = FUNC_WRITE_A;
                        r = IDX_W'($urandom_range(0, dim_a_rows - 1));
                        c = IDX_W'($urandom_range(0, dim_a_cols - 1));
                    end else begin
                        f = FUNC_WRITE_B;
                        r = IDX_W'($urandom_range(0, dim_b_rows - 1));
                        c = IDX_W'($urandom_range(0, dim_b_cols - 1));
                    end
                    send_item(f, r, c, pick_elem(), 1'b0, typed_res);
                end else begin
                    f = ($urandom_range(0, 1) == 0) ? FUNC_WRITE_A : FUNC_WRITE_B;
                    send_item(f, IDX_W'($urandom), IDX_W'($urandom), pick_elem(),
                              1'b0, typed_res);
                end
            end
            send_item(FUNC_MULTIPLY, IDX_W'($urandom), IDX_W'($urandom), pick_elem(),
                      1'b0, typed_res);
            if (phase == 1 || $urandom_range(0, 3) == 0) begin
                send_item(FUNC_MULTIPLY, IDX_W'($urandom), IDX_W'($urandom), pick_elem(),
                          1'b0, typed_res);
            end
            phase++;
        end

        settle();
        if (mismatches == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
